@@ rtl/rvce_pkg.sv @@
// Shared types, codes and helpers for the RV64C compressed execute block.
// Used by rvce_regfile, rvce_exec and rv64c_compressed_execute; depends on nothing.
package rvce_pkg;

  localparam int XLEN     = 64;
  localparam int NREGS    = 32;
  localparam int RIDX_W   = $clog2(NREGS);
  localparam int INSTR_W  = 16;

  // Exception codes
  localparam logic [2:0] EXC_NONE       = 3'd0;
  localparam logic [2:0] EXC_ILLEGAL    = 3'd1;
  localparam logic [2:0] EXC_LOAD_MIS   = 3'd2;
  localparam logic [2:0] EXC_STORE_MIS  = 3'd3;
  localparam logic [2:0] EXC_SEQUENCE   = 3'd4;

  // Quadrants (instruction bits 1:0)
  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;

  // funct3 codes, quadrant 0
  localparam logic [2:0] F3_ADDI4SPN = 3'd0;
  localparam logic [2:0] F3_LW       = 3'd2;
  localparam logic [2:0] F3_LD       = 3'd3;
  localparam logic [2:0] F3_SW       = 3'd6;
  localparam logic [2:0] F3_SD       = 3'd7;
  // funct3 codes, quadrant 1
  localparam logic [2:0] F3_ADDI     = 3'd0;
  localparam logic [2:0] F3_ADDIW    = 3'd1;
  localparam logic [2:0] F3_LI       = 3'd2;
  localparam logic [2:0] F3_LUI      = 3'd3;
  // funct3 codes, quadrant 2
  localparam logic [2:0] F3_MVADD    = 3'd4;
  localparam logic [2:0] F3_SWSP     = 3'd6;
  localparam logic [2:0] F3_SDSP     = 3'd7;

  localparam logic [RIDX_W-1:0] REG_ZERO = 5'd0;
  localparam logic [RIDX_W-1:0] REG_SP   = 5'd2;

  localparam logic [3:0] BYTES_WORD  = 4'd4;
  localparam logic [3:0] BYTES_DWORD = 4'd8;

  // One result word
  typedef struct packed {
    logic [2:0]        exception_code;
    logic [XLEN-1:0]   mem_wdata;
    logic [3:0]        mem_bytes;
    logic [XLEN-1:0]   mem_addr;
    logic              mem_write;
    logic              mem_request;
    logic [XLEN-1:0]   reg_value;
    logic [RIDX_W-1:0] reg_index;
    logic              reg_write;
  } result_t;

  // Write-back request to the register file
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [XLEN-1:0]   data;
  } wb_t;

  // Outstanding load tracking
  typedef struct packed {
    logic              pending;
    logic [RIDX_W-1:0] dest;
    logic              is_word;
  } ld_state_t;

  function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
    return {{(XLEN-32){v[31]}}, v};
  endfunction

endpackage

@@ rtl/rv64c_compressed_execute.sv @@
// Top level of the RV64C compressed execute block: input stage, register file,
// execute logic and output register. Uses rvce_pkg, rvce_regfile and rvce_exec.
//
// Usage
//   Input words arrive on s_axis. s_axis_tuser carries the action: 0 executes the
//   compressed instruction in s_axis_tdata[15:0], 1 returns the data of the
//   outstanding load in s_axis_tdata[79:16]. Every accepted word yields exactly
//   one result word on m_axis, in order, carrying the register write, the memory
//   request and the exception code.
//   Timing: the edge that takes an input word captures the word and its two
//   register-file reads in the read stage, and the edge that advances the read
//   stage loads the executed result into the output register.
//   Throughput is one word per cycle while m_axis_tready is high; the two
//   register reads of an instruction are done by the two read ports of the file in
//   the same cycle, and a result written in the cycle an operand is read is bypassed.
//   Reset clears the per-register valid bits, so every register reads zero at
//   once, with no clearing pass; no load is outstanding after reset.
//   When m_axis_tready is low the output register and the read stage hold, and
//   s_axis_tready falls once both are full. No word is dropped or repeated.
//   A load leaves its destination waiting; any instruction before the load data
//   returns is refused with a sequence error and leaves the load outstanding.
module rv64c_compressed_execute (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] instruction, [79:16] load_data
  input  logic [79:0]  s_axis_tdata,
  // [0] action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] reg_write, [5:1] reg_index, [69:6] reg_value, [70] mem_request,
  // [71] mem_write, [135:72] mem_addr, [139:136] mem_bytes,
  // [203:140] mem_wdata, [206:204] exception_code, [207] zero
  output logic [207:0] m_axis_tdata
);
  import rvce_pkg::*;

  // Read stage
  logic               s1_valid;
  logic               s1_action;
  logic [INSTR_W-1:0] s1_instr;
  logic [XLEN-1:0]    s1_ldata;

  // Output register
  result_t            out_q;

  // Load tracking
  ld_state_t          ld_state;
  ld_state_t          ld_state_next;

  logic               accept;
  logic               advance;
  logic [INSTR_W-1:0] in_instr;
  logic [RIDX_W-1:0]  addr_a;
  logic [RIDX_W-1:0]  addr_b;
  logic [XLEN-1:0]    op_a;
  logic [XLEN-1:0]    op_b;
  result_t            res;
  wb_t                wb_req;
  wb_t                wb;

  assign in_instr      = s_axis_tdata[15:0];
  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Operand addresses straight from the incoming instruction
  always_comb begin
    unique case (in_instr[1:0])
      QUAD0:   addr_a = (in_instr[15:13] == F3_ADDI4SPN) ? REG_SP
                                                         : {2'b01, in_instr[9:7]};
      QUAD1:   addr_a = in_instr[11:7];
      QUAD2:   addr_a = (in_instr[15:13] == F3_MVADD) ? in_instr[11:7] : REG_SP;
      default: addr_a = REG_ZERO;
    endcase
    addr_b = (in_instr[1:0] == QUAD0) ? {2'b01, in_instr[4:2]} : in_instr[6:2];
  end

  // Commit to the file only when the result moves on
  always_comb begin
    wb    = wb_req;
    wb.en = wb_req.en && advance;
  end

  rvce_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (op_a),
    .rd_data_b (op_b),
    .wb        (wb)
  );

  rvce_exec u_exec (
    .action  (s1_action),
    .instr   (s1_instr),
    .ldata   (s1_ldata),
    .op_a    (op_a),
    .op_b    (op_b),
    .ld_cur  (ld_state),
    .res     (res),
    .wb      (wb_req),
    .ld_next (ld_state_next)
  );

  // Control: stage valids and load tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      ld_state      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
        ld_state      <= ld_state_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action <= s_axis_tuser;
      s1_instr  <= in_instr;
      s1_ldata  <= s_axis_tdata[79:16];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {1'b0, out_q};

  // A held word in the read stage keeps its instruction
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_instr)))
    else $error("read stage lost or changed a held word");

  // An issued read leaves a load outstanding
  a_load_tracked: assert property (@(posedge clk) disable iff (rst)
    (advance && res.mem_request && !res.mem_write) |=> ld_state.pending)
    else $error("load issued without being tracked");

  // Never write x0
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    wb.en |-> (wb.idx != REG_ZERO))
    else $error("write to x0 reached the register file");

  // A request never carries an exception
  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_q.mem_request) |-> (out_q.exception_code == EXC_NONE))
    else $error("memory request issued together with an exception");

  // Load data while a load is outstanding clears it and writes the file
  a_load_return: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_action && ld_state.pending) |=> !ld_state.pending)
    else $error("load return did not clear the outstanding load");

endmodule

@@ rtl/rvce_regfile.sv @@
// Register file: 32 x 64 memory, two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset; same-edge writes bypass. Uses rvce_pkg.
module rvce_regfile (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [rvce_pkg::RIDX_W-1:0] rd_addr_a,
  input  logic [rvce_pkg::RIDX_W-1:0] rd_addr_b,
  output logic [rvce_pkg::XLEN-1:0]   rd_data_a,
  output logic [rvce_pkg::XLEN-1:0]   rd_data_b,
  input  rvce_pkg::wb_t               wb
);
  import rvce_pkg::*;

  logic [XLEN-1:0]  mem [NREGS];
  logic [NREGS-1:0] vld;
  logic [XLEN-1:0]  q_a;
  logic [XLEN-1:0]  q_b;
  logic             vq_a;
  logic             vq_b;
  logic             hit_a;
  logic             hit_b;
  logic [XLEN-1:0]  wd_q;

  always_ff @(posedge clk) begin
    if (wb.en) begin
      mem[wb.idx] <= wb.data;
    end
    if (rd_en) begin
      q_a <= mem[rd_addr_a];
      q_b <= mem[rd_addr_b];
    end
  end

  // Valid bits and bypass flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vq_a  <= 1'b0;
      vq_b  <= 1'b0;
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      if (wb.en) begin
        vld[wb.idx] <= 1'b1;
      end
      if (rd_en) begin
        vq_a  <= vld[rd_addr_a];
        vq_b  <= vld[rd_addr_b];
        hit_a <= wb.en && (wb.idx == rd_addr_a);
        hit_b <= wb.en && (wb.idx == rd_addr_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wb.en) begin
      wd_q <= wb.data;
    end
  end

  assign rd_data_a = hit_a ? wd_q : (vq_a ? q_a : '0);
  assign rd_data_b = hit_b ? wd_q : (vq_b ? q_b : '0);

endmodule

@@ rtl/rvce_exec.sv @@
// Execute stage: decodes one compressed instruction or load return word against
// the operands read from rvce_regfile. Pure logic; uses rvce_pkg.
module rvce_exec (
  input  logic                         action,
  input  logic [rvce_pkg::INSTR_W-1:0] instr,
  input  logic [rvce_pkg::XLEN-1:0]    ldata,
  input  logic [rvce_pkg::XLEN-1:0]    op_a,
  input  logic [rvce_pkg::XLEN-1:0]    op_b,
  input  rvce_pkg::ld_state_t          ld_cur,
  output rvce_pkg::result_t            res,
  output rvce_pkg::wb_t                wb,
  output rvce_pkg::ld_state_t          ld_next
);
  import rvce_pkg::*;

  logic [2:0]        f3;
  logic [RIDX_W-1:0] rdf;
  logic [RIDX_W-1:0] rs2f;
  logic [RIDX_W-1:0] rdp;
  logic [XLEN-1:0]   imm6;
  logic [6:0]        offw;
  logic [7:0]        offd;
  logic [9:0]        nz;
  logic [9:0]        raw16;
  logic [7:0]        offswsp;
  logic [8:0]        offsdsp;
  logic [XLEN-1:0]   sum_w;

  assign f3      = instr[15:13];
  assign rdf     = instr[11:7];
  assign rs2f    = instr[6:2];
  assign rdp     = {2'b01, instr[4:2]};
  assign imm6    = {{(XLEN-6){instr[12]}}, instr[12], instr[6:2]};
  assign offw    = {instr[5], instr[12:10], instr[6], 2'b00};
  assign offd    = {instr[6:5], instr[12:10], 3'b000};
  assign nz      = {instr[10:7], instr[12:11], instr[5], instr[6], 2'b00};
  assign raw16   = {instr[12], instr[4:3], instr[5], instr[2], instr[6], 4'b0000};
  assign offswsp = {instr[8:7], instr[12:9], 2'b00};
  assign offsdsp = {instr[9:7], instr[12:10], 3'b000};
  assign sum_w   = op_a + imm6;

  logic              do_wr;
  logic [RIDX_W-1:0] wr_idx;
  logic [XLEN-1:0]   wr_val;
  logic              do_mem;
  logic              is_store;
  logic              is_dw;
  logic [XLEN-1:0]   maddr;
  logic [XLEN-1:0]   mdata;
  logic              misal;
  logic [2:0]        exc;

  always_comb begin
    res      = '0;
    wb       = '0;
    ld_next  = ld_cur;
    do_wr    = 1'b0;
    wr_idx   = REG_ZERO;
    wr_val   = '0;
    do_mem   = 1'b0;
    is_store = 1'b0;
    is_dw    = 1'b0;
    maddr    = '0;
    mdata    = op_b;
    misal    = 1'b0;
    exc      = EXC_NONE;

    if (action) begin
      if (!ld_cur.pending) begin
        exc = EXC_SEQUENCE;
      end else begin
        do_wr           = 1'b1;
        wr_idx          = ld_cur.dest;
        wr_val          = ld_cur.is_word ? sext32(ldata[31:0]) : ldata;
        ld_next.pending = 1'b0;
      end
    end else if (ld_cur.pending) begin
      exc = EXC_SEQUENCE;
    end else begin
      unique case (instr[1:0])
        QUAD0: begin
          unique case (f3) inside
            F3_ADDI4SPN: begin
              if (nz == '0) begin
                exc = EXC_ILLEGAL;
              end else begin
                do_wr  = 1'b1;
                wr_idx = rdp;
                wr_val = op_a + {{(XLEN-10){1'b0}}, nz};
              end
            end
            F3_LW, F3_SW: begin
              do_mem   = 1'b1;
              is_store = (f3 == F3_SW);
              maddr    = op_a + {{(XLEN-7){1'b0}}, offw};
            end
            F3_LD, F3_SD: begin
              do_mem   = 1'b1;
              is_dw    = 1'b1;
              is_store = (f3 == F3_SD);
              maddr    = op_a + {{(XLEN-8){1'b0}}, offd};
            end
            default: exc = EXC_ILLEGAL;
          endcase
        end
        QUAD1: begin
          unique case (f3)
            F3_ADDI: begin
              do_wr  = 1'b1;
              wr_idx = rdf;
              wr_val = sum_w;
            end
            F3_ADDIW: begin
              if (rdf == REG_ZERO) begin
                exc = EXC_ILLEGAL;
              end else begin
                do_wr  = 1'b1;
                wr_idx = rdf;
                wr_val = sext32(sum_w[31:0]);
              end
            end
            F3_LI: begin
              if (rdf == REG_ZERO) begin
                exc = EXC_ILLEGAL;
              end else begin
                do_wr  = 1'b1;
                wr_idx = rdf;
                wr_val = imm6;
              end
            end
            F3_LUI: begin
              if (rdf == REG_SP) begin
                if (raw16 == '0) begin
                  exc = EXC_ILLEGAL;
                end else begin
                  do_wr  = 1'b1;
                  wr_idx = REG_SP;
                  wr_val = op_a + {{(XLEN-10){raw16[9]}}, raw16};
                end
              end else if (rdf == REG_ZERO || imm6 == '0) begin
                exc = EXC_ILLEGAL;
              end else begin
                do_wr  = 1'b1;
                wr_idx = rdf;
                wr_val = {imm6[XLEN-13:0], 12'h000};
              end
            end
            default: exc = EXC_ILLEGAL;
          endcase
        end
        QUAD2: begin
          unique case (f3)
            F3_MVADD: begin
              if (rs2f == REG_ZERO) begin
                exc = EXC_ILLEGAL;
              end else begin
                do_wr  = 1'b1;
                wr_idx = rdf;
                wr_val = instr[12] ? (op_a + op_b) : op_b;
              end
            end
            F3_SWSP: begin
              do_mem   = 1'b1;
              is_store = 1'b1;
              maddr    = op_a + {{(XLEN-8){1'b0}}, offswsp};
            end
            F3_SDSP: begin
              do_mem   = 1'b1;
              is_store = 1'b1;
              is_dw    = 1'b1;
              maddr    = op_a + {{(XLEN-9){1'b0}}, offsdsp};
            end
            default: exc = EXC_ILLEGAL;
          endcase
        end
        default: exc = EXC_ILLEGAL;
      endcase
    end

    // Memory access: check natural alignment, then issue
    if (do_mem) begin
      misal        = is_dw ? (maddr[2:0] != 3'b000) : (maddr[1:0] != 2'b00);
      res.mem_addr = maddr;
      if (misal) begin
        exc = is_store ? EXC_STORE_MIS : EXC_LOAD_MIS;
      end else begin
        res.mem_request = 1'b1;
        res.mem_write   = is_store;
        res.mem_bytes   = is_dw ? BYTES_DWORD : BYTES_WORD;
        if (is_store) begin
          res.mem_wdata = is_dw ? mdata : {32'h0, mdata[31:0]};
        end else begin
          ld_next.pending = 1'b1;
          ld_next.dest    = rdp;
          ld_next.is_word = !is_dw;
        end
      end
    end

    // Drop writes to x0
    if (do_wr && wr_idx != REG_ZERO) begin
      res.reg_write = 1'b1;
      res.reg_index = wr_idx;
      res.reg_value = wr_val;
      wb.en         = 1'b1;
      wb.idx        = wr_idx;
      wb.data       = wr_val;
    end

    res.exception_code = exc;
  end

endmodule

@@ dv/rvce_result_checker.sv @@
// Result checker for the RV64C compressed execute block: predicts each result
// word from the accepted input words and compares it field by field.
// Depends on rvce_pkg for the result layout and the instruction codes.
module rvce_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [207:0] m_axis_tdata,
  output int           mismatches,
  output int           awaiting
);
  import rvce_pkg::*;

  localparam int PAD_BIT = $bits(result_t);

  logic [XLEN-1:0] gpr [NREGS];
  ld_state_t       load_state;
  result_t         expected_q [$];
  int              n_mismatch = 0;
  int              n_wait = 0;

  assign mismatches = n_mismatch;
  assign awaiting   = n_wait;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    n_mismatch++;
  endtask

  task automatic compare_word(input result_t got, input result_t want, input logic pad);
    if (got.reg_write !== want.reg_write)
      flag_mismatch("reg_write", 64'(got.reg_write), 64'(want.reg_write));
    if (got.reg_index !== want.reg_index)
      flag_mismatch("reg_index", 64'(got.reg_index), 64'(want.reg_index));
    if (got.reg_value !== want.reg_value)
      flag_mismatch("reg_value", got.reg_value, want.reg_value);
    if (got.mem_request !== want.mem_request)
      flag_mismatch("mem_request", 64'(got.mem_request), 64'(want.mem_request));
    if (got.mem_write !== want.mem_write)
      flag_mismatch("mem_write", 64'(got.mem_write), 64'(want.mem_write));
    if (got.mem_addr !== want.mem_addr)
      flag_mismatch("mem_addr", got.mem_addr, want.mem_addr);
    if (got.mem_bytes !== want.mem_bytes)
      flag_mismatch("mem_bytes", 64'(got.mem_bytes), 64'(want.mem_bytes));
    if (got.mem_wdata !== want.mem_wdata)
      flag_mismatch("mem_wdata", got.mem_wdata, want.mem_wdata);
    if (got.exception_code !== want.exception_code)
      flag_mismatch("exception_code", 64'(got.exception_code), 64'(want.exception_code));
    if (pad !== 1'b0)
      flag_mismatch("pad bit", 64'(pad), 64'd0);
  endtask

  // Execute one input word against the shadow register file and load state.
  function automatic result_t execute_word(input logic act, input logic [15:0] w,
                                           input logic [63:0] data);
    result_t         r;
    logic [4:0]      rd, rs2, rdc, rs1c, wb_idx;
    logic [63:0]     imm6, wb_val, ea, st_data;
    logic [9:0]      nz, sp_raw;
    logic            wb_en, is_ld, is_st, bad, misaligned;
    logic [3:0]      nbytes;
    r       = '0;
    wb_en   = 1'b0;
    wb_idx  = REG_ZERO;
    wb_val  = '0;
    is_ld   = 1'b0;
    is_st   = 1'b0;
    bad     = 1'b0;
    nbytes  = '0;
    ea      = '0;
    st_data = '0;
    rd      = w[11:7];
    rs2     = w[6:2];
    rdc     = {2'b01, w[4:2]};
    rs1c    = {2'b01, w[9:7]};
    imm6    = {{58{w[12]}}, w[12], w[6:2]};
    nz      = {w[10:7], w[12:11], w[5], w[6], 2'b00};
    sp_raw  = {w[12], w[4:3], w[5], w[2], w[6], 4'b0000};

    if (act) begin
      if (!load_state.pending) begin
        r.exception_code = EXC_SEQUENCE;
      end else begin
        wb_en  = 1'b1;
        wb_idx = load_state.dest;
        wb_val = load_state.is_word ? {{32{data[31]}}, data[31:0]} : data;
        load_state.pending = 1'b0;
      end
    end else if (load_state.pending) begin
      r.exception_code = EXC_SEQUENCE;
    end else begin
      case (w[1:0])
        QUAD0: begin
          case (w[15:13]) inside
            F3_ADDI4SPN: begin
              bad    = (nz == '0);
              wb_en  = 1'b1;
              wb_idx = rdc;
              wb_val = gpr[REG_SP] + 64'(nz);
            end
            F3_LW, F3_SW: begin
              is_ld   = (w[15:13] == F3_LW);
              is_st   = !is_ld;
              nbytes  = BYTES_WORD;
              ea      = gpr[rs1c] + 64'({w[5], w[12:10], w[6], 2'b00});
              st_data = {32'd0, gpr[rdc][31:0]};
            end
            F3_LD, F3_SD: begin
              is_ld   = (w[15:13] == F3_LD);
              is_st   = !is_ld;
              nbytes  = BYTES_DWORD;
              ea      = gpr[rs1c] + 64'({w[6:5], w[12:10], 3'b000});
              st_data = gpr[rdc];
            end
            default: bad = 1'b1;
          endcase
        end
        QUAD1: begin
          wb_en  = 1'b1;
          wb_idx = rd;
          case (w[15:13])
            F3_ADDI:  wb_val = gpr[rd] + imm6;
            F3_ADDIW: begin
              bad    = (rd == REG_ZERO);
              wb_val = gpr[rd] + imm6;
              wb_val = {{32{wb_val[31]}}, wb_val[31:0]};
            end
            F3_LI: begin
              bad    = (rd == REG_ZERO);
              wb_val = imm6;
            end
            F3_LUI: begin
              if (rd == REG_SP) begin
                bad    = (sp_raw == '0);
                wb_val = gpr[REG_SP] + {{54{sp_raw[9]}}, sp_raw};
              end else begin
                bad    = (rd == REG_ZERO) || (imm6 == '0);
                wb_val = imm6 << 12;
              end
            end
            default: bad = 1'b1;
          endcase
        end
        QUAD2: begin
          case (w[15:13])
            F3_MVADD: begin
              bad    = (rs2 == REG_ZERO);
              wb_en  = 1'b1;
              wb_idx = rd;
              wb_val = w[12] ? gpr[rd] + gpr[rs2] : gpr[rs2];
            end
            F3_SWSP: begin
              is_st   = 1'b1;
              nbytes  = BYTES_WORD;
              ea      = gpr[REG_SP] + 64'({w[8:7], w[12:9], 2'b00});
              st_data = {32'd0, gpr[rs2][31:0]};
            end
            F3_SDSP: begin
              is_st   = 1'b1;
              nbytes  = BYTES_DWORD;
              ea      = gpr[REG_SP] + 64'({w[9:7], w[12:10], 3'b000});
              st_data = gpr[rs2];
            end
            default: bad = 1'b1;
          endcase
        end
        default: bad = 1'b1;
      endcase
    end

    if (bad) begin
      r.exception_code = EXC_ILLEGAL;
      wb_en = 1'b0;
    end else if (is_ld || is_st) begin
      r.mem_addr = ea;
      misaligned = (nbytes == BYTES_DWORD) ? (ea[2:0] != 3'd0) : (ea[1:0] != 2'd0);
      if (misaligned) begin
        r.exception_code = is_ld ? EXC_LOAD_MIS : EXC_STORE_MIS;
      end else begin
        r.mem_request = 1'b1;
        r.mem_write   = is_st;
        r.mem_bytes   = nbytes;
        if (is_st) r.mem_wdata = st_data;
        if (is_ld) begin
          load_state.pending = 1'b1;
          load_state.dest    = rdc;
          load_state.is_word = (nbytes == BYTES_WORD);
        end
      end
    end

    // x0 is never written; a write to it is a hint and reports nothing
    if (wb_en && wb_idx != REG_ZERO) begin
      gpr[wb_idx]   = wb_val;
      r.reg_write   = 1'b1;
      r.reg_index   = wb_idx;
      r.reg_value   = wb_val;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < NREGS; i++) gpr[i] = '0;
      load_state = '0;
      expected_q.delete();
    end else begin
      // retire first: a word taken at this edge cannot have its result yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result with nothing expected", m_axis_tdata[63:0], 64'd0);
        end else begin
          want = expected_q.pop_front();
          compare_word(result_t'(m_axis_tdata[PAD_BIT-1:0]), want, m_axis_tdata[PAD_BIT]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(execute_word(s_axis_tuser, s_axis_tdata[15:0],
                                          s_axis_tdata[79:16]));
    end
    n_wait = expected_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
// Top of the RV64C compressed execute testbench: clock, reset, stimulus,
// sink back-pressure, watchdog and verdict. Depends on rvce_pkg,
// rv64c_compressed_execute and rvce_result_checker.
module tb_top;
  import rvce_pkg::*;

  // Action codes carried on s_axis_tuser
  localparam logic ACT_EXEC = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  // Full register numbers used by the directed words
  localparam logic [4:0] RA = 5'd1;
  localparam logic [4:0] T0 = 5'd5;
  localparam logic [4:0] S0 = 5'd8;
  // Compressed 3-bit register fields (x8 + field)
  localparam logic [2:0] CS0 = 3'd0;
  localparam logic [2:0] CS1 = 3'd1;
  localparam logic [2:0] CA5 = 3'd7;
  // funct3 with no supported instruction in quadrants 0 and 2
  localparam logic [2:0] F3_UNSUP = 3'd1;

  localparam int TOTAL_WORDS = 950;
  localparam int QUIET_TAIL  = 150;
  localparam int SEG_WORDS   = 160;
  localparam int STALL_LIMIT = 1000;

  typedef enum int {
    K_ADDI4SPN, K_LW, K_LD, K_SW, K_SD, K_ADDI, K_ADDIW,
    K_LI, K_LUI, K_ADDI16SP, K_MV, K_ADD, K_SWSP, K_SDSP
  } op_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;

  int           mismatches;
  int           awaiting;
  int           words_sent = 0;
  int           quiet_cycles = 0;
  logic         src_gaps = 1'b0;
  logic         sink_stalls = 1'b1;

  rv64c_compressed_execute uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rvce_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .awaiting      (awaiting)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Drive one word from a falling edge and hold it until it is taken.
  // Optionally open a gap first; valid stays high between back-to-back words.
  task automatic send_word(input logic act, input logic [15:0] instr,
                           input logic [63:0] data);
    int gap;
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {data, instr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Load data: often 8-byte aligned so that it makes a usable base address,
  // now and then the all-zero and all-one extremes.
  function automatic logic [63:0] random_load_data();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 15)) inside
      0:       d = '0;
      1:       d = '1;
      [2:8]:   d[2:0] = 3'd0;
      default: ;
    endcase
    return d;
  endfunction

  // Random encoding of one supported instruction kind; the remaining bits
  // stay random, so illegal corners such as zero immediates turn up too.
  function automatic logic [15:0] make_instr(input op_kind_t k);
    logic [15:0] w;
    w = 16'($urandom);
    case (k)
      K_ADDI4SPN: w = {F3_ADDI4SPN, w[12:2], QUAD0};
      K_LW:       w = {F3_LW, w[12:2], QUAD0};
      K_LD:       w = {F3_LD, w[12:2], QUAD0};
      K_SW:       w = {F3_SW, w[12:2], QUAD0};
      K_SD:       w = {F3_SD, w[12:2], QUAD0};
      K_ADDI:     w = {F3_ADDI, w[12:2], QUAD1};
      K_ADDIW:    w = {F3_ADDIW, w[12:2], QUAD1};
      K_LI:       w = {F3_LI, w[12:2], QUAD1};
      K_LUI:      w = {F3_LUI, w[12:2], QUAD1};
      K_ADDI16SP: w = {F3_LUI, w[12], REG_SP, w[6:2], QUAD1};
      K_MV:       w = {F3_MVADD, 1'b0, w[11:2], QUAD2};
      K_ADD:      w = {F3_MVADD, 1'b1, w[11:2], QUAD2};
      K_SWSP:     w = {F3_SWSP, w[12:2], QUAD2};
      K_SDSP:     w = {F3_SDSP, w[12:2], QUAD2};
      default:    ;
    endcase
    return w;
  endfunction

  // Sink back-pressure: random stall bursts while enabled
  initial begin : sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int       pick;
    int       seg;
    logic     tail;
    op_kind_t kind;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: sequence errors, every instruction but ADDI and SD, illegal and hint
    // forms, misaligned accesses and word loads with sign extension.
    send_word(ACT_DATA, '0, '1);                                  // data, no load
    send_word(ACT_EXEC, {F3_LI, 1'b0, REG_ZERO, 5'd3, QUAD1}, '0); // LI to x0
    send_word(ACT_EXEC, {F3_LI, 1'b1, RA, 5'd0, QUAD1}, '0);      // LI ra, -32
    send_word(ACT_EXEC, {F3_LUI, 1'b0, REG_ZERO, 5'd1, QUAD1}, '0);
    send_word(ACT_EXEC, {F3_LUI, 1'b0, T0, 5'd0, QUAD1}, '0);     // LUI zero imm
    send_word(ACT_EXEC, {F3_LUI, 1'b0, T0, 5'h1f, QUAD1}, '0);
    send_word(ACT_EXEC, {F3_LW, 3'b000, CS0, 2'b00, CS0, QUAD0}, '0);
    send_word(ACT_EXEC, {F3_LI, 1'b0, RA, 5'd7, QUAD1}, '0);      // refused, load held
    send_word(ACT_DATA, '0, 64'h0000_0000_8000_0001);             // LW sign-extends
    send_word(ACT_EXEC, {F3_LD, 3'b111, CS0, 2'b11, CS1, QUAD0}, '0); // odd base
    send_word(ACT_EXEC, {F3_SW, 3'b000, CS0, 2'b00, CS1, QUAD0}, '0);
    send_word(ACT_EXEC, {F3_LUI, 1'b0, REG_SP, 5'd0, QUAD1}, '0); // ADDI16SP zero
    send_word(ACT_EXEC, {F3_LUI, 1'b1, REG_SP, 5'd0, QUAD1}, '0); // ADDI16SP -512
    send_word(ACT_EXEC, 16'h0000, '0);                            // ADDI4SPN zero
    send_word(ACT_EXEC, {F3_ADDI4SPN, 8'hff, CA5, QUAD0}, '0);
    send_word(ACT_EXEC, {F3_ADDIW, 1'b0, REG_ZERO, 5'd1, QUAD1}, '0);
    send_word(ACT_EXEC, {F3_ADDIW, 1'b0, S0, 5'h1f, QUAD1}, '0);
    send_word(ACT_EXEC, {F3_MVADD, 1'b0, T0, REG_ZERO, QUAD2}, '0); // rs2 = x0
    send_word(ACT_EXEC, {F3_MVADD, 1'b0, T0, RA, QUAD2}, '0);
    send_word(ACT_EXEC, {F3_MVADD, 1'b1, REG_ZERO, RA, QUAD2}, '0); // ADD hint
    send_word(ACT_EXEC, {F3_MVADD, 1'b1, T0, T0, QUAD2}, '0);
    send_word(ACT_EXEC, {F3_SDSP, 6'h3f, T0, QUAD2}, '0);
    send_word(ACT_EXEC, {F3_SWSP, 6'h3f, RA, QUAD2}, '0);
    send_word(ACT_EXEC, {F3_LW, 3'b000, CA5, 2'b00, CS1, QUAD0}, '0);
    send_word(ACT_DATA, '0, '1);
    send_word(ACT_EXEC, 16'hffff, '0);                            // quadrant 3
    send_word(ACT_EXEC, {F3_UNSUP, 11'h7ff, QUAD0}, '0);
    send_word(ACT_EXEC, {F3_UNSUP, 11'h000, QUAD2}, '0);

    // Random: mostly supported instructions, each load followed by its data,
    // with some raw encodings, stray data and words refused mid-load.
    while (words_sent < TOTAL_WORDS) begin
      seg         = words_sent / SEG_WORDS;
      tail        = (words_sent >= TOTAL_WORDS - QUIET_TAIL);
      src_gaps    = !tail && (seg % 3 != 1);
      sink_stalls = !tail && (seg % 3 != 2);
      pick        = $urandom_range(0, 99);
      if (pick < 5) begin
        send_word(ACT_DATA, 16'($urandom), random_load_data());
      end else if (pick < 15) begin
        send_word(ACT_EXEC, 16'($urandom), {$urandom, $urandom});
      end else begin
        kind = (pick < 35) ? (($urandom_range(0, 1) == 0) ? K_LW : K_LD)
                           : op_kind_t'($urandom_range(0, 13));
        send_word(ACT_EXEC, make_instr(kind), {$urandom, $urandom});
        if (kind == K_LW || kind == K_LD) begin
          if ($urandom_range(0, 9) == 0)
            send_word(ACT_EXEC, 16'($urandom), {$urandom, $urandom});
          send_word(ACT_DATA, 16'($urandom), random_load_data());
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the pipeline latency for any stray result
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ rv64c_compressed_execute.f @@
rtl/rvce_pkg.sv
rtl/rvce_regfile.sv
rtl/rvce_exec.sv
rtl/rv64c_compressed_execute.sv
dv/rvce_result_checker.sv
dv/tb_top.sv
